### design/sbh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbh_pkg: shared types and constants for the string bucket hash core
// Holds the sequencer states, the remainder unit status and the hash constants.
// ----------------------------------------------------------------------------
package sbh_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned HASH_W      = 32;
    localparam int unsigned SIZE_W      = 16;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned APB_ADDR_W  = 3;

    // one remainder step per dividend bit
    localparam int unsigned DIV_STEPS   = HASH_W;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [HASH_W-1:0] WEIGHT_BIAS = 32'd7;
    localparam logic [HASH_W-1:0] SUM_BIAS    = 32'd11;
    localparam logic [HASH_W-1:0] SUM_RESET   = 32'd1;
    localparam logic [SIZE_W-1:0] SIZE_RESET  = 16'd1024;

    // register index taken from paddr[2]
    localparam logic REG_TABLE_SIZE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV
    } sbh_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sbh_rem_stat_t;

    function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c inside {[8'h61:8'h7A]})
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

### design/sbh_rem_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbh_rem_unit: iterative 32-by-16 remainder
// Restoring shift-subtract, one dividend bit per cycle through one subtractor.
// ----------------------------------------------------------------------------
module sbh_rem_unit
    import sbh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [HASH_W-1:0]   dividend,
    input  logic [SIZE_W-1:0]   divisor,
    output sbh_rem_stat_t       stat,
    output logic [SIZE_W-1:0]   remainder
);

    logic [HASH_W-1:0]    dividend_reg, dividend_next;
    logic [SIZE_W-1:0]    divisor_reg,  divisor_next;
    logic [SIZE_W-1:0]    rem_reg,      rem_next;
    logic [DIV_CNT_W-1:0] count_reg,    count_next;
    logic                 busy_reg,     busy_next;
    logic                 done_reg,     done_next;
    logic [SIZE_W:0]      trial;
    logic [SIZE_W:0]      diff;

    assign trial = {rem_reg, dividend_reg[HASH_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};

    always_comb
    begin
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        count_next    = count_reg;
        busy_next     = busy_reg;
        done_next     = done_reg;
        if (start)
        begin
            dividend_next = dividend;
            divisor_next  = divisor;
            rem_next      = '0;
            count_next    = '0;
            busy_next     = 1'b1;
            done_next     = 1'b0;
        end
        else if (busy_reg)
        begin
            // partial remainder stays below the divisor, so 16 bits hold it
            rem_next      = (trial >= {1'b0, divisor_reg}) ? diff[SIZE_W-1:0]
                                                            : trial[SIZE_W-1:0];
            dividend_next = {dividend_reg[HASH_W-2:0], 1'b0};
            count_next    = count_reg + DIV_CNT_W'(1);
            if (count_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

### design/string_bucket_hash_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_bucket_hash_core: streaming bucket hash of a character key
// Hashes a key one character word at a time and emits its bucket index.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, char_in, last): one character word per
//   transfer, first to last; the final word carries last and is not hashed.
//   An empty key is sent as char_in 0 with last set.
//   Output channel (out_valid / out_stall, bucket): one word per key, sent
//   when the last word has been taken; bucket = hash sum mod table_size
//   (0 when table_size is 0).
//   APB port: register 0 at byte address 0 is table_size (16 bits).
// Sequence:
//   A non-final character goes through accept/weight update, the 8x32
//   multiply, then the sum accumulate. The final word starts the bit-serial
//   remainder unit, whose result is then loaded into the output register.
//   in_stall is high whenever the sequencer is not idle.
// Reset clears the key state (weight 0, sum 1, expecting first character),
// sets table_size to 1024 and drops out_valid. A stalled output word is held
// in the output register; the next key's words, its final word too, are still
// taken, and only its bucket waits in the remainder state for the output register.
// ----------------------------------------------------------------------------
module string_bucket_hash_core
    import sbh_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // input channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [CHAR_W-1:0]       char_in,
    input  logic                    last,
    // output channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [SIZE_W-1:0]       bucket,
    // APB configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    sbh_state_t          state_reg, state_next;

    // key state
    logic [HASH_W-1:0]   weight_reg,   weight_next;
    logic [HASH_W-1:0]   sum_reg,      sum_next;
    logic                at_start_reg, at_start_next;

    // datapath registers
    logic [CHAR_W-1:0]   char_reg,     char_next;
    logic [HASH_W-1:0]   prod_reg,     prod_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [SIZE_W-1:0]   bucket_reg,    bucket_next;

    logic [SIZE_W-1:0]   table_size_reg, table_size_next;

    // handshakes and sequencer controls
    logic                in_accept;
    logic                out_free;
    logic                load_out;
    logic                rem_start;
    logic                cfg_write;

    logic [CHAR_W-1:0]          char_up;
    logic [HASH_W-1:0]          weight_base;
    logic [HASH_W+CHAR_W-1:0]   prod_full;
    logic [HASH_W-1:0]          prod_x3;

    sbh_rem_stat_t       rem_stat;
    logic [SIZE_W-1:0]   rem_value;

    // ------------------------------------------------------------------
    // APB: always ready, table_size at index 0
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        table_size_next = table_size_reg;
        if (cfg_write && paddr[2] == REG_TABLE_SIZE)
        begin
            table_size_next = pwdata[SIZE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TABLE_SIZE)
        begin
            prdata = {{(APB_DATA_W-SIZE_W){1'b0}}, table_size_reg};
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    assign in_accept = in_valid & ~in_stall;
    assign out_free  = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = last ? ST_DIV : ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:  state_next = ST_IDLE;
            ST_DIV:
            begin
                if (rem_stat.done && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall  = 1'b1;
        rem_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                rem_start = in_valid & last;
            end
            ST_MUL:  in_stall = 1'b1;
            ST_ACC:  in_stall = 1'b1;
            ST_DIV:  load_out = rem_stat.done & out_free;
            default: in_stall = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Hash datapath
    // ------------------------------------------------------------------
    assign char_up     = to_upper(char_in);
    // first character seeds the weight with itself plus 7
    assign weight_base = at_start_reg ? ({{(HASH_W-CHAR_W){1'b0}}, char_up} + WEIGHT_BIAS)
                                      : weight_reg;
    assign prod_full   = {{HASH_W{1'b0}}, char_reg} * {{CHAR_W{1'b0}}, weight_reg};
    assign prod_x3     = {prod_reg[HASH_W-2:0], 1'b0} + prod_reg;

    always_comb
    begin
        weight_next   = weight_reg;
        sum_next      = sum_reg;
        at_start_next = at_start_reg;
        char_next     = char_reg;
        prod_next     = prod_reg;
        if (in_accept)
        begin
            if (last)
            begin
                // sum is captured by the remainder unit this cycle
                weight_next   = '0;
                sum_next      = SUM_RESET;
                at_start_next = 1'b1;
            end
            else
            begin
                weight_next   = weight_base + {{(HASH_W-CHAR_W){1'b0}}, char_up};
                at_start_next = 1'b0;
                char_next     = char_up;
            end
        end
        if (state_reg == ST_MUL)
        begin
            prod_next = prod_full[HASH_W-1:0];
        end
        if (state_reg == ST_ACC)
        begin
            sum_next = sum_reg + prod_x3 + SUM_BIAS;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        bucket_next    = bucket_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            bucket_next    = (table_size_reg == '0) ? '0 : rem_value;
        end
    end

    assign out_valid = out_valid_reg;
    assign bucket    = bucket_reg;

    sbh_rem_unit u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (sum_reg),
        .divisor   (table_size_reg),
        .stat      (rem_stat),
        .remainder (rem_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            weight_reg     <= '0;
            sum_reg        <= SUM_RESET;
            at_start_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
            table_size_reg <= SIZE_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            weight_reg     <= weight_next;
            sum_reg        <= sum_next;
            at_start_reg   <= at_start_next;
            out_valid_reg  <= out_valid_next;
            table_size_reg <= table_size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg   <= char_next;
        prod_reg   <= prod_next;
        bucket_reg <= bucket_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        rem_stat.busy |-> in_stall)
        else $error("input taken while remainder unit busy");

    a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && table_size_reg != '0) |-> (bucket_reg < table_size_reg))
        else $error("bucket not below table size");

    a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DIV))
        else $error("output word raised outside remainder state");

    a_key_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last) |=> (at_start_reg && sum_reg == SUM_RESET))
        else $error("key state not cleared after final word");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for string_bucket_hash_core
// Streams character keys into the core and folds each accepted word through a
// bench-side copy of the hash. Every bucket word is checked against it. The
// table size is moved through its extremes and a set of typical values while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import sbh_pkg::*;

    // Longest stretch with no transfer on any port before the run is called hung.
    // The slowest correct case is a final word through the remainder unit behind
    // a long output stall and a long input gap, so this is many times the real worst case.
    localparam int unsigned HANG_LIMIT   = 3000;
    // Remainder unit plus output load, with margin. Used before register writes
    // and at the end of the run.
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned PHASE_WORDS  = 100;

    localparam logic [APB_ADDR_W-1:0] ADDR_TABLE_SIZE = {REG_TABLE_SIZE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED   = {~REG_TABLE_SIZE, 2'b00};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [CHAR_W-1:0]     char_in   = '0;
    logic                  last      = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [SIZE_W-1:0]     bucket;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Bench-side hash state, kept in step with every accepted input word.
    logic [HASH_W-1:0]     key_weight = '0;
    logic [HASH_W-1:0]     key_sum    = SUM_RESET;
    logic                  key_fresh  = 1'b1;
    logic [SIZE_W-1:0]     size_cfg   = SIZE_RESET;

    // Buckets predicted but not yet seen on the output channel, oldest first.
    logic [SIZE_W-1:0]     pending_buckets[$];
    logic [SIZE_W-1:0]     want_bucket;

    int                    err_cnt     = 0;
    int unsigned           quiet_count = 0;
    int unsigned           stall_run   = 0;
    int unsigned           phase_words = 0;
    // Random gaps on both channels; cleared for stretches of full-rate traffic.
    bit                    idle_on     = 1'b1;

    string_bucket_hash_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_in   (char_in),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .bucket    (bucket),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Gap length: mostly none, often a few cycles, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 25);
    endfunction

    // Key characters: lowercase letters (case mapping), printable ASCII, or any
    // byte at all so every bit of char_in toggles and the high half is covered.
    function automatic logic [CHAR_W-1:0] rand_char();
        int unsigned r;
        r = $urandom_range(0, 3);
        if (r == 0)
        begin
            return CHAR_W'($urandom_range(8'h61, 8'h7A));
        end
        else if (r == 1)
        begin
            return CHAR_W'($urandom_range(8'h20, 8'h7F));
        end
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // Fold one accepted word into the bench hash. A word with last set is never
    // hashed: it closes the key, queues sum mod size and clears the key state.
    task automatic fold_char(input logic [CHAR_W-1:0] raw, input logic fin);
        logic [HASH_W-1:0] c;
        logic [HASH_W-1:0] rem;
        c = {{(HASH_W-CHAR_W){1'b0}}, raw};
        if (raw >= 8'h61 && raw <= 8'h7A)
        begin
            c = c - 32'h20;
        end
        if (fin)
        begin
            // zero table size gives bucket 0 rather than a divide fault
            rem = '0;
            if (size_cfg != '0)
            begin
                rem = key_sum % {{(HASH_W-SIZE_W){1'b0}}, size_cfg};
            end
            pending_buckets.push_back(rem[SIZE_W-1:0]);
            key_weight = '0;
            key_sum    = SUM_RESET;
            key_fresh  = 1'b1;
        end
        else
        begin
            // weight seeds from the first character, then every hashed
            // character adds itself before it is folded into the sum
            if (key_fresh)
            begin
                key_weight = c + WEIGHT_BIAS;
                key_fresh  = 1'b0;
            end
            key_weight = key_weight + c;
            key_sum    = key_sum + c * key_weight * 32'd3 + SUM_BIAS;
        end
    endtask

    // Send one character word. in_valid stays high into the next word when no
    // gap is drawn, so back-to-back words never drop valid in between.
    task automatic push_char(input logic [CHAR_W-1:0] ch, input logic fin);
        int unsigned gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= ch;
        last     <= fin;
        do
            @(posedge clk);
        while (in_stall);
        fold_char(ch, fin);
        phase_words++;
    endtask

    task automatic send_key(input logic [CHAR_W-1:0] chars[$]);
        foreach (chars[i])
        begin
            push_char(chars[i], i == chars.size() - 1);
        end
    endtask

    // Bring the core to idle: input quiet, every bucket back, remainder unit done.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_buckets.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Setup cycle then access cycle; the register takes the data at the edge
    // where the access phase sees pready.
    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_TABLE_SIZE)
        begin
            size_cfg = data[SIZE_W-1:0];
        end
    endtask

    // Upper data bits are random: only the low 16 bits reach table_size.
    task automatic set_size(input logic [SIZE_W-1:0] sz);
        apb_write(ADDR_TABLE_SIZE, {16'($urandom), sz});
    endtask

    // Reset table size 1024: empty key, an empty key with a nonzero final byte, then
    // a key that walks the case-mapping edges, a zero byte mid-key and the top of the byte.
    task automatic test_directed_keys();
        push_char(8'h00, 1'b1);
        push_char(8'h71, 1'b1);
        send_key('{8'h61, 8'h7A, 8'h60, 8'h7B, 8'h00, 8'hFF,
                   8'h80, 8'h7F, 8'h41, 8'h5A, 8'hFF});
        settle();
    endtask

    // Zero size, the smallest and the largest table.
    task automatic test_size_extremes();
        set_size(16'd0);
        send_key('{8'h61, 8'h42, 8'h63});
        settle();
        set_size(16'd1);
        send_key('{8'h7A, 8'h00});
        settle();
        set_size(16'hFFFF);
        send_key('{8'h7A, 8'h7A, 8'h01});
        settle();
    endtask

    // A write past the register map must leave table_size as it was.
    task automatic test_unmapped_write();
        apb_write(ADDR_UNMAPPED, $urandom);
        send_key('{8'hC3, 8'h5E});
        settle();
    endtask

    // Random keys over a spread of table sizes. Most keys are short, a few long;
    // a body of zero gives empty keys. Every fourth phase runs without gaps or
    // stalls to hit full rate.
    task automatic test_random_keys();
        logic [SIZE_W-1:0] sizes[$];
        int unsigned       body;
        int unsigned       r;
        sizes = '{16'hFFFF, 16'd1, 16'd0, 16'd2, 16'd3, 16'd97, 16'd256,
                  16'd4096, 16'd40000, 16'($urandom_range(1, 65535))};
        foreach (sizes[p])
        begin
            set_size(sizes[p]);
            idle_on     = (p % 4 != 2);
            phase_words = 0;
            while (phase_words < PHASE_WORDS)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                begin
                    body = $urandom_range(0, 10);
                end
                else if (r < 95)
                begin
                    body = $urandom_range(11, 30);
                end
                else
                begin
                    body = $urandom_range(31, 60);
                end
                repeat (body) push_char(rand_char(), 1'b0);
                if ($urandom_range(0, 9) == 0)
                begin
                    push_char(8'h00, 1'b1);
                end
                else
                begin
                    push_char(rand_char(), 1'b1);
                end
            end
            settle();
        end
        idle_on = 1'b1;
    endtask

    // Output side: random stall runs, broken by short free stretches.
    always @(posedge clk)
    begin
        if (!idle_on)
        begin
            out_stall <= 1'b0;
            stall_run = 0;
        end
        else if (stall_run != 0)
        begin
            stall_run = stall_run - 1;
        end
        else if (out_stall)
        begin
            out_stall <= 1'b0;
            stall_run = $urandom_range(0, 8);
        end
        else
        begin
            stall_run = pick_gap();
            if (stall_run != 0)
            begin
                out_stall <= 1'b1;
                stall_run = stall_run - 1;
            end
        end
    end

    // Check each accepted bucket word against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_buckets.size() == 0)
            begin
                $error("bucket word with nothing expected: bucket actual %0d", bucket);
                err_cnt++;
            end
            else
            begin
                want_bucket = pending_buckets.pop_front();
                if (bucket !== want_bucket)
                begin
                    $error("bucket mismatch: expected %0d, actual %0d",
                           want_bucket, bucket);
                    err_cnt++;
                end
            end
        end
    end

    // Hang detector: any transfer on either channel or the APB port resets it.
    // Missing bucket words also land here, since nothing moves while we wait.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            begin
                quiet_count <= 0;
            end
            else
            begin
                quiet_count <= quiet_count + 1;
            end
            if (quiet_count >= HANG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_keys();
        test_size_extremes();
        test_unmapped_write();
        test_random_keys();
        if (err_cnt == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
design/sbh_pkg.sv
design/sbh_rem_unit.sv
design/string_bucket_hash_core.sv
dv/tb_top.sv
